[hw/rtl/assert_macros.svh]
// Assertion macros shared by the motor command framer RTL.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every clock edge outside reset.
`define CMFR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("cmfr assertion failed");

// Same-cycle implication.
`define CMFR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cmfr implication failed");

`endif

[hw/rtl/cmfr_pkg.sv]
// Package for the motor command framer: codes, limits and shared types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cmfr_pkg;

    // Command codes
    localparam logic [2:0] CMD_SET      = 3'd0;
    localparam logic [2:0] CMD_TICK     = 3'd1;
    localparam logic [2:0] CMD_ENABLE   = 3'd2;
    localparam logic [2:0] CMD_ESTOP    = 3'd3;
    localparam logic [2:0] CMD_WD_RESET = 3'd4;

    // Reply / status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;
    localparam logic [1:0] ST_SAFETY  = 2'd3;

    // Target modes
    localparam logic [1:0] MODE_DIRECT   = 2'd0;
    localparam logic [1:0] MODE_VELOCITY = 2'd1;
    localparam logic [1:0] MODE_DUTY     = 2'd2;
    localparam logic [1:0] MODE_INVALID  = 2'd3;

    // Config register indexes
    localparam logic [1:0] CFG_FB_CAN_ID  = 2'd0;
    localparam logic [1:0] CFG_SPEED_GAIN = 2'd1;
    localparam logic [1:0] CFG_WD_TIMEOUT = 2'd2;
    localparam logic [1:0] CFG_UNIT_ID    = 2'd3;

    localparam logic [9:0]  FB_CAN_ID_RST  = 10'h201;
    localparam logic [15:0] SPEED_GAIN_RST = 16'd256;
    localparam logic [15:0] WD_TIMEOUT_RST = 16'd100;
    localparam logic [7:0]  UNIT_ID_RST    = 8'd0;

    // Gain of 10.0 in Q8.8; above it the motor is voltage driven
    localparam logic [15:0] GAIN_TEN_Q8 = 16'd2560;

    localparam logic [16:0] TICK_MAX = 17'h1FFFF;

    localparam logic [15:0] VOLT_LIMIT = 16'd30000;
    localparam logic [15:0] CURR_LIMIT = 16'd16384;
    localparam logic [15:0] DUTY_VOLT  = 16'd30000;
    localparam logic [15:0] DUTY_CURR  = 16'd10000;
    localparam logic [9:0]  VEL_CURR_K = 10'd1000;

    // Feedback id ranges and frame ids
    localparam logic [9:0]  FB_BASE_LO  = 10'h201;
    localparam logic [9:0]  FB_BASE_MID = 10'h205;
    localparam logic [9:0]  FB_BASE_HI  = 10'h209;
    localparam logic [9:0]  FB_TOP_LO   = 10'h204;
    localparam logic [9:0]  FB_TOP_HI   = 10'h20B;
    localparam logic [10:0] FRAME_ID_LO  = 11'h200;
    localparam logic [10:0] FRAME_ID_MID = 11'h1FF;
    localparam logic [10:0] FRAME_ID_HI  = 11'h2FF;

    localparam int QUEUE_DEPTH_DEF = 2;

    typedef struct packed {
        logic [9:0]  fb_can_id;
        logic [15:0] speed_gain;
        logic [15:0] wd_timeout;
        logic [7:0]  unit_id;
    } t_cfg;

    // One classified command travelling from front to back end
    typedef struct packed {
        logic [1:0]  reply;
        logic [1:0]  status;
        logic        enabled;
        logic [15:0] timeouts;
        logic        frame_valid;
        logic        scaled;      // frame carries a scaled target, else zero
        logic        neg;
        logic [31:0] mag;
        logic [15:0] mult_b;      // gain, duty scale or one
        logic        vel_cur;     // velocity mode on a current-type motor
        logic        shift24;     // product is Q24, else Q16
        logic        volt;
        logic [10:0] frame_id;
        logic [1:0]  slot;
    } t_job;

    typedef struct packed {
        logic [1:0]  reply_code;
        logic [1:0]  stored_status;
        logic        is_enabled;
        logic [15:0] timeouts_seen;
        logic        frame_valid;
        logic [10:0] frame_id;
        logic [63:0] frame_data;
    } t_result;

endpackage

[hw/rtl/cmfr_front.sv]
// Front end: accepts command beats, updates watchdog/enable/status state,
// and pushes a classified job. Depends on cmfr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cmfr_front import cmfr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_command,
    input  logic [7:0]         i_motor_id,
    input  logic               i_enable,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_target_value,
    input  logic               i_full,
    output logic               o_push,
    output t_job               o_job
);

    logic [16:0] r_elapsed, n_elapsed;
    logic        r_fired, n_fired;
    logic        r_enabled, n_enabled;
    logic [1:0]  r_status, n_status;
    logic [15:0] r_total, n_total;

    logic [16:0] tick_inc;
    logic        fire;
    logic        tick_fire;
    logic        volt;
    logic [9:0]  base;
    t_job        job;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;
    assign o_job   = job;

    assign volt      = i_cfg.speed_gain > GAIN_TEN_Q8;
    assign tick_inc  = (r_elapsed == TICK_MAX) ? r_elapsed : r_elapsed + 17'd1;
    assign fire      = (tick_inc > {1'b0, i_cfg.wd_timeout}) && !r_fired;
    assign tick_fire = o_push && (i_command == CMD_TICK) && fire;

    always_comb begin
        if (volt) begin
            base = (i_cfg.fb_can_id >= FB_BASE_HI) ? FB_BASE_HI : FB_BASE_MID;
        end else begin
            base = (i_cfg.fb_can_id >= FB_BASE_MID) ? FB_BASE_MID : FB_BASE_LO;
        end
    end

    always_comb begin
        n_elapsed = r_elapsed;
        n_fired   = r_fired;
        n_enabled = r_enabled;
        n_status  = r_status;
        n_total   = r_total;

        job             = '0;
        job.reply       = ST_OK;
        job.volt        = volt;
        job.slot        = 2'(i_cfg.fb_can_id - base);
        job.neg         = i_target_value[31];
        job.mag         = i_target_value[31] ? 32'(-i_target_value) : 32'(i_target_value);
        job.vel_cur     = (i_mode == MODE_VELOCITY) && !volt;
        job.shift24     = (i_mode == MODE_VELOCITY);
        if (volt) begin
            job.frame_id = (i_cfg.fb_can_id >= FB_BASE_HI &&
                            i_cfg.fb_can_id <= FB_TOP_HI) ? FRAME_ID_HI : FRAME_ID_MID;
        end else begin
            job.frame_id = (i_cfg.fb_can_id >= FB_BASE_LO &&
                            i_cfg.fb_can_id <= FB_TOP_LO) ? FRAME_ID_LO : FRAME_ID_MID;
        end
        case (i_mode)
            MODE_VELOCITY: job.mult_b = i_cfg.speed_gain;
            MODE_DUTY:     job.mult_b = volt ? DUTY_VOLT : DUTY_CURR;
            default:       job.mult_b = 16'd1;
        endcase

        case (i_command)
            CMD_SET: begin
                if (i_motor_id != i_cfg.unit_id) begin
                    job.reply = ST_INVALID;
                end else begin
                    n_elapsed = '0;
                    n_fired   = 1'b0;
                    if (!i_enable) begin
                        job.frame_valid = 1'b1;
                        n_enabled       = 1'b0;
                    end else begin
                        n_enabled = 1'b1;
                        if (i_mode == MODE_INVALID) begin
                            job.reply = ST_INVALID;
                        end else begin
                            job.frame_valid = 1'b1;
                            job.scaled      = 1'b1;
                            n_status        = ST_OK;
                        end
                    end
                end
            end
            CMD_TICK: begin
                n_elapsed = tick_inc;
                if (fire) begin
                    n_fired         = 1'b1;
                    n_status        = ST_TIMEOUT;
                    n_total         = r_total + 16'd1;
                    job.frame_valid = 1'b1;
                end
                job.reply = n_status;
            end
            CMD_ENABLE: begin
                job.frame_valid = !i_enable;
                n_enabled       = i_enable;
            end
            CMD_ESTOP: begin
                job.frame_valid = 1'b1;
                n_enabled       = 1'b0;
                n_status        = ST_SAFETY;
                job.reply       = ST_SAFETY;
            end
            CMD_WD_RESET: begin
                n_elapsed = '0;
                n_fired   = 1'b0;
                if (r_status == ST_TIMEOUT) begin
                    n_status = ST_OK;
                end
            end
            default: begin
                job.reply = ST_INVALID;
            end
        endcase

        if (!job.scaled) begin
            job.neg = 1'b0;
        end
        job.status   = n_status;
        job.enabled  = n_enabled;
        job.timeouts = n_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= '0;
            r_fired   <= 1'b0;
            r_enabled <= 1'b0;
            r_status  <= ST_OK;
            r_total   <= '0;
        end else if (o_push) begin
            r_elapsed <= n_elapsed;
            r_fired   <= n_fired;
            r_enabled <= n_enabled;
            r_status  <= n_status;
            r_total   <= n_total;
        end
    end

    `CMFR_ASSERT(a_fire_sets_timeout, tick_fire |=> (r_fired && r_status == ST_TIMEOUT))

endmodule

[hw/rtl/cmfr_queue.sv]
// Short job queue between front and back end.
// Depends on cmfr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cmfr_queue import cmfr_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_head,
    output logic o_full,
    output logic o_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `CMFR_ASSERT_IMPL(a_no_overflow, o_full, !i_push || i_pop)

endmodule

[hw/rtl/cmfr_back.sv]
// Back end: scales the target (multiply, shift, saturate), builds the CAN
// frame and holds the result beat. Depends on cmfr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cmfr_back import cmfr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_empty,
    input  t_job    i_head,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_MUL   = 4'b0010,
        S_SCALE = 4'b0100,
        S_OUT   = 4'b1000
    } t_bstate;

    t_bstate     r_state, n_state;
    t_job        r_job;
    logic [47:0] r_prod;
    logic [31:0] r_q;
    logic        r_sat;
    t_result     r_out;
    logic        r_out_valid;

    logic        load_out;
    logic [39:0] prod_k;
    logic [15:0] lim;
    logic [15:0] mag_v;
    logic [15:0] val;
    logic [63:0] data;

    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign load_out = (r_state == S_OUT) && (!r_out_valid || !i_stall);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // Current-type velocity needs a second factor; large products saturate anyway
    assign prod_k = 40'(r_prod[29:0] * VEL_CURR_K);

    assign lim   = r_job.volt ? VOLT_LIMIT : CURR_LIMIT;
    assign mag_v = (r_sat || r_q > {16'd0, lim}) ? lim : r_q[15:0];
    assign val   = r_job.neg ? 16'(-mag_v) : mag_v;

    always_comb begin
        case (r_job.slot)
            2'd0:    data = {val, 48'd0};
            2'd1:    data = {16'd0, val, 32'd0};
            2'd2:    data = {32'd0, val, 16'd0};
            default: data = {48'd0, val};
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (!i_empty) n_state = i_head.scaled ? S_MUL : S_OUT;
            S_MUL:   n_state = S_SCALE;
            S_SCALE: n_state = S_OUT;
            S_OUT:   if (load_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head;
            r_q   <= '0;
            r_sat <= 1'b0;
        end
        if (r_state == S_MUL) begin
            r_prod <= r_job.mag * r_job.mult_b;
        end
        if (r_state == S_SCALE) begin
            if (r_job.vel_cur) begin
                r_q   <= {16'd0, prod_k[39:24]};
                r_sat <= |r_prod[47:30];
            end else if (r_job.shift24) begin
                r_q   <= {8'd0, r_prod[47:24]};
                r_sat <= 1'b0;
            end else begin
                r_q   <= r_prod[47:16];
                r_sat <= 1'b0;
            end
        end
        if (load_out) begin
            r_out.reply_code    <= r_job.reply;
            r_out.stored_status <= r_job.status;
            r_out.is_enabled    <= r_job.enabled;
            r_out.timeouts_seen <= r_job.timeouts;
            r_out.frame_valid   <= r_job.frame_valid;
            r_out.frame_id      <= r_job.frame_valid ? r_job.frame_id : 11'd0;
            r_out.frame_data    <= r_job.frame_valid ? data : 64'd0;
        end
    end

    `CMFR_ASSERT_IMPL(a_no_frame_is_zero, r_out_valid && !r_out.frame_valid, r_out.frame_id == 11'd0 && r_out.frame_data == 64'd0)
    `CMFR_ASSERT_IMPL(a_mul_only_scaled, r_state == S_MUL, r_job.scaled && r_job.frame_valid)

endmodule

[hw/rtl/can_motor_command_framer.sv]
// Accepted beats are queued. The back end pops one at a time in S_IDLE; scaled
// set commands then pass S_MUL (32x16 multiply) and S_SCALE (shift/second
// multiply), other commands go straight to S_OUT, which saturates, builds the
// frame and loads the output register when it is empty or being taken. The
// front takes a beat per cycle until the job queue fills.
// Reset (synchronous, active low) clears control state and loads config defaults.
`timescale 1ns / 1ps

module can_motor_command_framer import cmfr_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // config write port
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_wdata,
    // command channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_command,
    input  logic [7:0]         i_motor_id,
    input  logic               i_enable,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_target_value,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_reply_code,
    output logic [1:0]         o_stored_status,
    output logic               o_is_enabled,
    output logic [15:0]        o_timeouts_seen,
    output logic               o_frame_valid,
    output logic [10:0]        o_frame_id,
    output logic [63:0]        o_frame_data
);

    // Config registers. Writes must happen only while the block is idle (the user's
    // duty, not enforced), so front and back end (via the job) see stable values.
    t_cfg    r_cfg;

    t_job    front_job;
    logic    front_push;
    t_job    q_head;
    logic    q_full;
    logic    q_empty;
    logic    back_pop;
    t_result back_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fb_can_id  <= FB_CAN_ID_RST;
            r_cfg.speed_gain <= SPEED_GAIN_RST;
            r_cfg.wd_timeout <= WD_TIMEOUT_RST;
            r_cfg.unit_id    <= UNIT_ID_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FB_CAN_ID:  r_cfg.fb_can_id  <= i_cfg_wdata[9:0];
                CFG_SPEED_GAIN: r_cfg.speed_gain <= i_cfg_wdata;
                CFG_WD_TIMEOUT: r_cfg.wd_timeout <= i_cfg_wdata;
                CFG_UNIT_ID:    r_cfg.unit_id    <= i_cfg_wdata[7:0];
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    // Front: classifies each command beat, owns the watchdog, enable flag,
    // status and timeout count, and precomputes the multiplier operand,
    // frame id and slot so the back end needs no config.
    cmfr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (i_in_valid),
        .o_stall        (o_in_stall),
        .i_command      (i_command),
        .i_motor_id     (i_motor_id),
        .i_enable       (i_enable),
        .i_mode         (i_mode),
        .i_target_value (i_target_value),
        .i_full         (q_full),
        .o_push         (front_push),
        .o_job          (front_job)
    );

    // Job queue: front keeps taking beats while the back end multiplies.
    cmfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_job   (front_job),
        .i_pop   (back_pop),
        .o_head  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back: scale, saturate, place the 16-bit value in its slot, and hold
    // the result beat in an output register until the sink takes it.
    cmfr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (q_empty),
        .i_head   (q_head),
        .o_pop    (back_pop),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (back_result)
    );

    assign o_reply_code    = back_result.reply_code;
    assign o_stored_status = back_result.stored_status;
    assign o_is_enabled    = back_result.is_enabled;
    assign o_timeouts_seen = back_result.timeouts_seen;
    assign o_frame_valid   = back_result.frame_valid;
    assign o_frame_id      = back_result.frame_id;
    assign o_frame_data    = back_result.frame_data;

endmodule

[dv/can_motor_command_framer_tb.sv]
// Self-checking testbench for can_motor_command_framer: directed table, then random phases.
// Has its own transaction-level predictor of the framer; depends on cmfr_pkg and the RTL only.
`timescale 1ns / 1ps

module can_motor_command_framer_tb;
    import cmfr_pkg::*;

    localparam int          BLOCK_LATENCY = 6;       // settle time before a register write
    localparam int          DRAIN_CYCLES  = 16;
    localparam int          CYCLE_LIMIT   = 2_000_000;
    localparam logic [2:0]  CMD_UNDEFINED = 3'd7;
    localparam t_result     NO_CHECK      = '0;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  reg_idx;
        logic [15:0] reg_val;
        logic [2:0]  cmd;
        logic [7:0]  mid;
        logic        en;
        logic [1:0]  mode;
        logic [31:0] tgt;
        bit          typed;     // want holds a hand-written expectation
        t_result     want;
    } stim_row_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_idx;
    logic [15:0]        i_cfg_wdata;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [2:0]         i_command;
    logic [7:0]         i_motor_id;
    logic               i_enable;
    logic [1:0]         i_mode;
    logic signed [31:0] i_target_value;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [1:0]         o_reply_code;
    logic [1:0]         o_stored_status;
    logic               o_is_enabled;
    logic [15:0]        o_timeouts_seen;
    logic               o_frame_valid;
    logic [10:0]        o_frame_id;
    logic [63:0]        o_frame_data;

    can_motor_command_framer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_motor_id      (i_motor_id),
        .i_enable        (i_enable),
        .i_mode          (i_mode),
        .i_target_value  (i_target_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_reply_code    (o_reply_code),
        .o_stored_status (o_stored_status),
        .o_is_enabled    (o_is_enabled),
        .o_timeouts_seen (o_timeouts_seen),
        .o_frame_valid   (o_frame_valid),
        .o_frame_id      (o_frame_id),
        .o_frame_data    (o_frame_data)
    );

    always #1 i_clk = ~i_clk;

    // Predictor copy of the registers and the framer state
    logic [9:0]  fb_id;
    logic [15:0] gain_q8;
    logic [15:0] wd_limit;
    logic [7:0]  unit_sel;
    logic [16:0] ticks_since_reset;
    logic        wd_tripped;
    logic        drive_on;
    logic [1:0]  status_now;
    logic [15:0] trips_total;

    t_result replies_due[$];
    int      mismatch_count = 0;
    int      results_seen = 0;
    int      cycle_count = 0;
    int      tx_pct = 0;
    int      rx_pct = 0;
    int      hold_req = 0;
    int      hold_left = 0;

    // ---------------------------------------------------------------- predictor

    function automatic t_result with_frame(input t_result res, input logic [15:0] v);
        logic       volt;
        logic [9:0] base;
        logic [1:0] slot;
        volt = gain_q8 > GAIN_TEN_Q8;
        if (volt) begin
            base = (fb_id >= FB_BASE_HI) ? FB_BASE_HI : FB_BASE_MID;
            res.frame_id = (fb_id >= FB_BASE_HI && fb_id <= FB_TOP_HI) ? FRAME_ID_HI
                                                                       : FRAME_ID_MID;
        end else begin
            base = (fb_id >= FB_BASE_MID) ? FB_BASE_MID : FB_BASE_LO;
            res.frame_id = (fb_id >= FB_BASE_LO && fb_id <= FB_TOP_LO) ? FRAME_ID_LO
                                                                       : FRAME_ID_MID;
        end
        // slot wraps modulo 4, also for ids outside the type's range
        slot = 2'(fb_id - base);
        res.frame_valid = 1'b1;
        res.frame_data  = {48'd0, v} << (48 - 16 * int'(slot));
        return res;
    endfunction

    function automatic t_result frame_command(input stim_row_t r);
        t_result     res;
        logic        volt;
        logic        neg;
        logic [31:0] traw;
        logic [63:0] mag;
        logic [63:0] q;
        logic [63:0] lim;
        logic [15:0] v;
        res  = '0;
        volt = gain_q8 > GAIN_TEN_Q8;
        traw = r.tgt;
        neg  = traw[31];
        mag  = neg ? {32'd0, 32'd0 - traw} : {32'd0, traw};
        case (r.cmd)
            CMD_SET: begin
                if (r.mid != unit_sel) begin
                    res.reply_code = ST_INVALID;
                end else begin
                    ticks_since_reset = '0;
                    wd_tripped = 1'b0;
                    if (!r.en) begin
                        res = with_frame(res, 16'd0);
                        drive_on = 1'b0;
                    end else begin
                        drive_on = 1'b1;
                        if (r.mode == MODE_INVALID) begin
                            res.reply_code = ST_INVALID;
                        end else begin
                            lim = volt ? 64'(VOLT_LIMIT) : 64'(CURR_LIMIT);
                            case (r.mode)
                                MODE_DIRECT:   q = mag >> 16;
                                MODE_VELOCITY: q = volt ? (mag * 64'(gain_q8)) >> 24
                                    : (mag * 64'(gain_q8) * 64'(VEL_CURR_K)) >> 24;
                                default:       q = (mag * (volt ? 64'(DUTY_VOLT)
                                                                : 64'(DUTY_CURR))) >> 16;
                            endcase
                            // clamp first, then cut to 16 bits
                            if (q > lim) q = lim;
                            v = q[15:0];
                            if (neg) v = 16'd0 - v;
                            res = with_frame(res, v);
                            status_now = ST_OK;
                        end
                    end
                end
            end
            CMD_TICK: begin
                if (ticks_since_reset != TICK_MAX) ticks_since_reset = ticks_since_reset + 1'b1;
                if (ticks_since_reset > {1'b0, wd_limit} && !wd_tripped) begin
                    wd_tripped  = 1'b1;
                    status_now  = ST_TIMEOUT;
                    trips_total = trips_total + 1'b1;
                    res = with_frame(res, 16'd0);
                end
                res.reply_code = status_now;
            end
            CMD_ENABLE: begin
                if (!r.en) res = with_frame(res, 16'd0);
                drive_on = r.en;
            end
            CMD_ESTOP: begin
                res = with_frame(res, 16'd0);
                drive_on = 1'b0;
                status_now = ST_SAFETY;
                res.reply_code = ST_SAFETY;
            end
            CMD_WD_RESET: begin
                ticks_since_reset = '0;
                wd_tripped = 1'b0;
                if (status_now == ST_TIMEOUT) status_now = ST_OK;
            end
            default: res.reply_code = ST_INVALID;
        endcase
        res.stored_status = status_now;
        res.is_enabled    = drive_on;
        res.timeouts_seen = trips_total;
        return res;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic stim_row_t cmd_row(input logic [2:0] cmd, input logic [7:0] mid,
                                          input logic en, input logic [1:0] mode,
                                          input logic [31:0] tgt, input bit typed,
                                          input t_result want);
        stim_row_t r;
        r = '{is_cfg: 1'b0, reg_idx: CFG_FB_CAN_ID, reg_val: '0, cmd: cmd, mid: mid,
              en: en, mode: mode, tgt: tgt, typed: typed, want: want};
        return r;
    endfunction

    function automatic stim_row_t reg_row(input logic [1:0] idx, input logic [15:0] val);
        stim_row_t r;
        r = cmd_row(CMD_TICK, '0, 1'b0, MODE_DIRECT, '0, 1'b0, NO_CHECK);
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic logic [31:0] random_target();
        logic [31:0] v;
        case ($urandom_range(5))
            0: v = $urandom();
            1: v = {12'd0, 20'($urandom())};                     // a few units
            2: v = {8'd0, 24'($urandom())};
            3: v = {16'($urandom_range(16385, 16383)), 16'($urandom())};  // current limit
            4: v = {16'($urandom_range(30001, 29999)), 16'($urandom())};  // voltage limit
            default: v = ($urandom_range(1) != 0) ? 32'h7FFF_FFFF : 32'h0001_0000;
        endcase
        if ($urandom_range(1) != 0) v = 32'd0 - v;
        return v;
    endfunction

    // Mostly well-formed set commands and ticks; unused fields carry noise
    function automatic stim_row_t random_command();
        stim_row_t r;
        int        pick;
        r = cmd_row(CMD_TICK, 8'($urandom()), 1'($urandom()), 2'($urandom()), $urandom(),
                    1'b0, NO_CHECK);
        pick = $urandom_range(99);
        if (pick < 45) begin
            r.cmd  = CMD_SET;
            r.mid  = ($urandom_range(9) != 0) ? unit_sel : 8'($urandom());
            r.en   = ($urandom_range(7) != 0);
            r.mode = ($urandom_range(9) == 0) ? MODE_INVALID
                                              : 2'($urandom_range(int'(MODE_DUTY)));
            r.tgt  = random_target();
        end else if (pick < 75) begin
            r.cmd = CMD_TICK;
        end else if (pick < 82) begin
            r.cmd = CMD_ENABLE;
        end else if (pick < 87) begin
            r.cmd = CMD_ESTOP;
        end else if (pick < 97) begin
            r.cmd = CMD_WD_RESET;
        end else begin
            r.cmd = 3'($urandom_range(int'(CMD_UNDEFINED), int'(CMD_WD_RESET) + 1));
        end
        return r;
    endfunction

    // One beat on the command channel; prediction happens at acceptance
    task automatic send_command(input stim_row_t r);
        t_result want;
        if (tx_pct != 0 && $urandom_range(99) < tx_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_pct);
        end
        i_in_valid     <= 1'b1;
        i_command      <= r.cmd;
        i_motor_id     <= r.mid;
        i_enable       <= r.en;
        i_mode         <= r.mode;
        i_target_value <= r.tgt;
        do @(posedge i_clk); while (o_in_stall);
        want = frame_command(r);
        if (r.typed) want = r.want;
        replies_due.push_back(want);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (BLOCK_LATENCY) @(posedge i_clk);
    endtask

    // Caller lowers the write enable after the last write of a batch
    task automatic write_register(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            CFG_FB_CAN_ID:  fb_id    = val[9:0];
            CFG_SPEED_GAIN: gain_q8  = val;
            CFG_WD_TIMEOUT: wd_limit = val;
            default:        unit_sel = val[7:0];
        endcase
    endtask

    task automatic start_phase(input logic [15:0] fb, input logic [15:0] gain,
                               input logic [15:0] wd, input logic [15:0] unit,
                               input int tx, input int rx);
        wait_idle();
        write_register(CFG_FB_CAN_ID, fb);
        write_register(CFG_SPEED_GAIN, gain);
        write_register(CFG_WD_TIMEOUT, wd);
        write_register(CFG_UNIT_ID, unit);
        i_cfg_we <= 1'b0;
        tx_pct = tx;
        rx_pct = rx;
    endtask

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %h want %h",
                                      results_seen, name, got, want));
    endtask

    task automatic check_reply(input t_result got);
        t_result want;
        if (replies_due.size() == 0) begin
            report_mismatch($sformatf("result beat %h with nothing pending", got));
            return;
        end
        want = replies_due.pop_front();
        check_field("reply_code", 64'(got.reply_code), 64'(want.reply_code));
        check_field("stored_status", 64'(got.stored_status), 64'(want.stored_status));
        check_field("is_enabled", 64'(got.is_enabled), 64'(want.is_enabled));
        check_field("timeouts_seen", 64'(got.timeouts_seen), 64'(want.timeouts_seen));
        check_field("frame_valid", 64'(got.frame_valid), 64'(want.frame_valid));
        check_field("frame_id", 64'(got.frame_id), 64'(want.frame_id));
        check_field("frame_data", got.frame_data, want.frame_data);
        results_seen++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0)
            check_reply(t_result'{o_reply_code, o_stored_status, o_is_enabled,
                                  o_timeouts_seen, o_frame_valid, o_frame_id, o_frame_data});
    end

    // Result-side stall: random per phase, or a counted hold-off on request
    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= (rx_pct != 0) && ($urandom_range(99) < rx_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL can_motor_command_framer");
            $finish;
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial begin
        stim_row_t directed_rows[$];
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_FB_CAN_ID;
        i_cfg_wdata    = '0;
        i_in_valid     = 1'b0;
        i_command      = CMD_TICK;
        i_motor_id     = '0;
        i_enable       = 1'b0;
        i_mode         = MODE_DIRECT;
        i_target_value = '0;
        i_out_stall    = 1'b0;

        fb_id             = FB_CAN_ID_RST;
        gain_q8           = SPEED_GAIN_RST;
        wd_limit          = WD_TIMEOUT_RST;
        unit_sel          = UNIT_ID_RST;
        ticks_since_reset = '0;
        wd_tripped        = 1'b0;
        drive_on          = 1'b0;
        status_now        = ST_OK;
        trips_total       = '0;

        // Reset defaults: current type, feedback 0x201 -> frame 0x200, slot 0
        directed_rows.push_back(cmd_row(CMD_ESTOP, 8'h00, 1'b0, MODE_DIRECT, 32'd0, 1'b1,
            t_result'{ST_SAFETY, ST_SAFETY, 1'b0, 16'd0, 1'b1, FRAME_ID_LO, 64'd0}));
        directed_rows.push_back(cmd_row(CMD_UNDEFINED, 8'h00, 1'b1, MODE_DIRECT, 32'd0, 1'b1,
            t_result'{ST_INVALID, ST_SAFETY, 1'b0, 16'd0, 1'b0, 11'd0, 64'd0}));
        // watchdog reset leaves a safety status alone
        directed_rows.push_back(cmd_row(CMD_WD_RESET, 8'h00, 1'b0, MODE_DIRECT, 32'd0, 1'b1,
            t_result'{ST_OK, ST_SAFETY, 1'b0, 16'd0, 1'b0, 11'd0, 64'd0}));
        // wrong unit
        directed_rows.push_back(cmd_row(CMD_SET, 8'hFF, 1'b1, MODE_DIRECT, 32'h7FFF_FFFF,
            1'b1, t_result'{ST_INVALID, ST_SAFETY, 1'b0, 16'd0, 1'b0, 11'd0, 64'd0}));
        // set with enable clear: zero frame, status kept
        directed_rows.push_back(cmd_row(CMD_SET, 8'h00, 1'b0, MODE_DIRECT, 32'h7FFF_FFFF,
            1'b1, t_result'{ST_OK, ST_SAFETY, 1'b0, 16'd0, 1'b1, FRAME_ID_LO, 64'd0}));
        // invalid mode enables the drive but sends nothing
        directed_rows.push_back(cmd_row(CMD_SET, 8'h00, 1'b1, MODE_INVALID, 32'h0001_0000,
            1'b1, t_result'{ST_INVALID, ST_SAFETY, 1'b1, 16'd0, 1'b0, 11'd0, 64'd0}));
        // direct extremes saturate to +-16384
        directed_rows.push_back(cmd_row(CMD_SET, 8'h00, 1'b1, MODE_DIRECT, 32'h7FFF_FFFF,
            1'b1, t_result'{ST_OK, ST_OK, 1'b1, 16'd0, 1'b1, FRAME_ID_LO,
                            64'h4000_0000_0000_0000}));
        directed_rows.push_back(cmd_row(CMD_SET, 8'h00, 1'b1, MODE_DIRECT, 32'h8000_0000,
            1'b1, t_result'{ST_OK, ST_OK, 1'b1, 16'd0, 1'b1, FRAME_ID_LO,
                            64'hC000_0000_0000_0000}));
        // truncation toward zero on both signs
        directed_rows.push_back(cmd_row(CMD_SET, 8'h00, 1'b1, MODE_DIRECT, 32'h0001_8000,
            1'b0, NO_CHECK));
        directed_rows.push_back(cmd_row(CMD_SET, 8'h00, 1'b1, MODE_DIRECT, 32'hFFFE_8000,
            1'b0, NO_CHECK));
        directed_rows.push_back(cmd_row(CMD_SET, 8'h00, 1'b1, MODE_VELOCITY, 32'h7FFF_FFFF,
            1'b0, NO_CHECK));
        directed_rows.push_back(cmd_row(CMD_SET, 8'h00, 1'b1, MODE_VELOCITY, 32'h0001_0000,
            1'b0, NO_CHECK));
        directed_rows.push_back(cmd_row(CMD_SET, 8'h00, 1'b1, MODE_DUTY, 32'h0001_0000,
            1'b0, NO_CHECK));
        directed_rows.push_back(cmd_row(CMD_SET, 8'h00, 1'b1, MODE_DUTY, 32'hFFFF_FFFF,
            1'b0, NO_CHECK));
        directed_rows.push_back(cmd_row(CMD_ENABLE, 8'h00, 1'b1, MODE_DIRECT, 32'd0, 1'b1,
            t_result'{ST_OK, ST_OK, 1'b1, 16'd0, 1'b0, 11'd0, 64'd0}));
        directed_rows.push_back(cmd_row(CMD_ENABLE, 8'h00, 1'b0, MODE_DIRECT, 32'd0, 1'b1,
            t_result'{ST_OK, ST_OK, 1'b0, 16'd0, 1'b1, FRAME_ID_LO, 64'd0}));
        directed_rows.push_back(cmd_row(CMD_TICK, 8'h00, 1'b0, MODE_DIRECT, 32'd0, 1'b0,
            NO_CHECK));
        // zero timeout: the next tick trips the watchdog, the one after does not
        directed_rows.push_back(reg_row(CFG_WD_TIMEOUT, 16'd0));
        directed_rows.push_back(cmd_row(CMD_TICK, 8'h00, 1'b0, MODE_DIRECT, 32'd0, 1'b1,
            t_result'{ST_TIMEOUT, ST_TIMEOUT, 1'b0, 16'd1, 1'b1, FRAME_ID_LO, 64'd0}));
        directed_rows.push_back(cmd_row(CMD_TICK, 8'h00, 1'b0, MODE_DIRECT, 32'd0, 1'b0,
            NO_CHECK));
        directed_rows.push_back(cmd_row(CMD_WD_RESET, 8'h00, 1'b0, MODE_DIRECT, 32'd0, 1'b1,
            t_result'{ST_OK, ST_OK, 1'b0, 16'd1, 1'b0, 11'd0, 64'd0}));
        // voltage type, top feedback id
        directed_rows.push_back(reg_row(CFG_SPEED_GAIN, 16'hFFFF));
        directed_rows.push_back(reg_row(CFG_FB_CAN_ID, 16'h020B));
        directed_rows.push_back(cmd_row(CMD_SET, 8'h00, 1'b1, MODE_VELOCITY, 32'h7FFF_FFFF,
            1'b0, NO_CHECK));
        directed_rows.push_back(cmd_row(CMD_SET, 8'h00, 1'b1, MODE_DUTY, 32'h8000_0000,
            1'b0, NO_CHECK));
        // feedback ids outside any range, slot wraps
        directed_rows.push_back(reg_row(CFG_FB_CAN_ID, 16'h03FF));
        directed_rows.push_back(reg_row(CFG_UNIT_ID, 16'h00FF));
        directed_rows.push_back(cmd_row(CMD_SET, 8'hFF, 1'b1, MODE_DIRECT, 32'h1234_5678,
            1'b0, NO_CHECK));
        directed_rows.push_back(reg_row(CFG_FB_CAN_ID, 16'h0000));
        directed_rows.push_back(reg_row(CFG_SPEED_GAIN, 16'h0000));
        directed_rows.push_back(cmd_row(CMD_ESTOP, 8'h00, 1'b0, MODE_DIRECT, 32'd0, 1'b0,
            NO_CHECK));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            if (directed_rows[k].is_cfg) begin
                wait_idle();
                write_register(directed_rows[k].reg_idx, directed_rows[k].reg_val);
                i_cfg_we <= 1'b0;
            end else begin
                send_command(directed_rows[k]);
            end
        end

        // Random phases: register settings and idling change together
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: start_phase(16'h0201, 16'd0, 16'd0, 16'd0, 0, 0);
                1: start_phase(16'h020B, 16'hFFFF, 16'd5, 16'h00FF, 72, 0);
                2: start_phase(16'(16'h0201 + $urandom_range(10)), 16'd2560, 16'd3,
                               16'($urandom_range(255)), 0, 72);
                3: start_phase(16'(16'h0201 + $urandom_range(10)), 16'd2561, 16'd10,
                               16'($urandom_range(255)), 12, 12);
                // junk above the register widths must be dropped
                4: start_phase(16'($urandom()), 16'($urandom()), 16'($urandom_range(30)),
                               16'($urandom()), 0, 0);
                default: start_phase(16'h0204, 16'($urandom()), 16'd1, 16'h005A, 72, 0);
            endcase
            // long receiver hold-off while the sender keeps offering: input backs up
            if (p == 0) hold_req = 300;
            for (int n = 0; n < ((p == 0 || p >= 4) ? 100 : 150); n++)
                send_command(random_command());
        end

        // Largest timeout: a short run of ticks must not trip the watchdog
        start_phase(16'h0209, 16'd3000, 16'hFFFF, 16'h0080, 0, 0);
        send_command(cmd_row(CMD_WD_RESET, 8'h00, 1'b0, MODE_DIRECT, 32'd0, 1'b0, NO_CHECK));
        repeat (20)
            send_command(cmd_row(CMD_TICK, 8'h00, 1'b0, MODE_DIRECT, 32'd0, 1'b0, NO_CHECK));
        send_command(cmd_row(CMD_WD_RESET, 8'h00, 1'b0, MODE_DIRECT, 32'd0, 1'b0, NO_CHECK));

        i_in_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && replies_due.size() == 0) begin
            $display("PASS can_motor_command_framer");
        end else begin
            $display("FAIL can_motor_command_framer");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/cmfr_pkg.sv
hw/rtl/cmfr_front.sv
hw/rtl/cmfr_queue.sv
hw/rtl/cmfr_back.sv
hw/rtl/can_motor_command_framer.sv
dv/can_motor_command_framer_tb.sv
